@@ hw/rtl/integer_stack_alu_with_power_top_macros.svh @@
// Assertion macros for the integer stack ALU.
// Used by integer_stack_alu_with_power_top; needs clk and rst in scope.
`ifndef INTEGER_STACK_ALU_WITH_POWER_TOP_MACROS_SVH
`define INTEGER_STACK_ALU_WITH_POWER_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ISA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ISA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/isa_pkg.sv @@
// Shared types and constants for the integer stack ALU.
// No dependencies.
package isa_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_W      = 64;
  localparam int HALF_W      = DATA_W / 2;
  localparam int TOP_W       = 64;
  localparam int DEPTH_W     = 7;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(DATA_W);

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_POW  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_UNDER  = 3'd1,
    ST_OVER   = 3'd2,
    ST_DIVZ   = 3'd3,
    ST_NEGEXP = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    MS_AB,
    MS_R_BASE,
    MS_BASE_SQ
  } mul_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_DIV_FIN,
    S_POW_CHK,
    S_POW_MR,
    S_POW_SQ,
    S_WRITE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic     load_in;
    logic     wr_push;
    logic     load_a;
    logic     set_arith;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     take_mul_r;
    logic     take_mul_base;
    logic     pow_init;
    logic     div_init;
    logic     div_step;
    logic     div_fin;
    logic     wr_result;
    logic     status_en;
    status_t  status_code;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic lt2;
    logic b_zero;
    logic b_neg;
    logic ex_zero;
    logic ex_lsb;
    logic div_last;
    logic mul_done;
  } stat_t;

endpackage

@@ hw/rtl/isa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module isa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/isa_mul.sv @@
// Wrapping multiplier: low DATA_W bits of x*y from three half-width products.
// Depends on isa_pkg. One shared half-width multiplier forms the three products in turn.
module isa_mul (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [isa_pkg::DATA_W-1:0] x,
  input  logic [isa_pkg::DATA_W-1:0] y,
  output logic                      done,
  output logic [isa_pkg::DATA_W-1:0] p
);
  import isa_pkg::*;

  logic              busy;
  logic [1:0]        phase;
  logic [DATA_W-1:0] xq;
  logic [DATA_W-1:0] yq;
  logic [DATA_W-1:0] prod;
  logic [DATA_W-1:0] acc;
  logic [HALF_W-1:0] ma;
  logic [HALF_W-1:0] mb;
  logic [DATA_W-1:0] prod_sh;

  always_comb begin
    case (phase)
      2'd0: begin
        ma = xq[HALF_W-1:0];
        mb = yq[HALF_W-1:0];
      end
      2'd1: begin
        ma = xq[HALF_W-1:0];
        mb = yq[DATA_W-1:HALF_W];
      end
      default: begin
        ma = xq[DATA_W-1:HALF_W];
        mb = yq[HALF_W-1:0];
      end
    endcase
  end

  assign prod_sh = {prod[HALF_W-1:0], {HALF_W{1'b0}}};
  assign done    = busy && (phase == 2'd3);
  assign p       = acc + prod_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 2'd0;
    end else if (start) begin
      busy  <= 1'b1;
      phase <= 2'd0;
    end else if (busy) begin
      phase <= phase + 2'd1;
      if (phase == 2'd3) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xq <= x;
      yq <= y;
    end
    prod <= ma * mb;
    case (phase)
      2'd1:    acc <= prod;
      2'd2:    acc <= acc + prod_sh;
      default: acc <= acc;
    endcase
  end

endmodule

@@ hw/rtl/isa_dp.sv @@
// Datapath: stack RAM, top-of-stack register, divider, power loop, output word.
// Depends on isa_pkg, isa_ram and isa_mul.
module isa_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  isa_pkg::cmd_t               cmd,
  output isa_pkg::stat_t              stat,
  input  logic [2:0]                  in_op,
  input  logic [63:0]                 in_value,
  output logic [isa_pkg::TOP_W-1:0]   out_top,
  output logic [isa_pkg::DEPTH_W-1:0] out_depth,
  output logic [2:0]                  out_status
);
  import isa_pkg::*;

  op_t               op_q;
  logic [DATA_W-1:0] val_q;
  logic [SP_W-1:0]   sp;
  logic [SP_W-1:0]   sp_m2;
  logic [DATA_W-1:0] tos;
  logic [DATA_W-1:0] a_q;
  logic [DATA_W-1:0] r_q;
  logic [DATA_W-1:0] base_q;
  logic [DATA_W-1:0] ex_q;
  logic [DATA_W-1:0] rem_q;
  logic [DATA_W-1:0] quo_q;
  logic [DATA_W-1:0] dvs_q;
  logic [CNT_W-1:0]  cnt;
  logic              neg_q;
  status_t           status_q;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;

  logic              mul_done;
  logic [DATA_W-1:0] mul_p;
  logic [DATA_W-1:0] mul_x;
  logic [DATA_W-1:0] mul_y;

  logic [DATA_W:0]   div_sh;
  logic [DATA_W:0]   div_diff;
  logic [DATA_W-1:0] mag_a;
  logic [DATA_W-1:0] mag_b;

  assign sp_m2     = sp - SP_W'(2);
  assign ram_we    = cmd.wr_push || cmd.wr_result;
  assign ram_waddr = cmd.wr_push ? sp[ADDR_W-1:0] : sp_m2[ADDR_W-1:0];
  assign ram_wdata = cmd.wr_push ? val_q : r_q;

  isa_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(sp_m2[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  always_comb begin
    unique case (cmd.mul_sel)
      MS_AB: begin
        mul_x = a_q;
        mul_y = tos;
      end
      MS_R_BASE: begin
        mul_x = r_q;
        mul_y = base_q;
      end
      MS_BASE_SQ: begin
        mul_x = base_q;
        mul_y = base_q;
      end
      default: begin
        mul_x = a_q;
        mul_y = tos;
      end
    endcase
  end

  isa_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.mul_start),
    .x    (mul_x),
    .y    (mul_y),
    .done (mul_done),
    .p    (mul_p)
  );

  assign mag_a    = a_q[DATA_W-1] ? (DATA_W'(0) - a_q) : a_q;
  assign mag_b    = tos[DATA_W-1] ? (DATA_W'(0) - tos) : tos;
  assign div_sh   = {rem_q, quo_q[DATA_W-1]};
  assign div_diff = div_sh - {1'b0, dvs_q};

  assign stat.op       = op_q;
  assign stat.full     = (sp == SP_W'(STACK_DEPTH));
  assign stat.lt2      = (sp < SP_W'(2));
  assign stat.b_zero   = (tos == '0);
  assign stat.b_neg    = tos[DATA_W-1];
  assign stat.ex_zero  = (ex_q == '0);
  assign stat.ex_lsb   = ex_q[0];
  assign stat.div_last = (cnt == CNT_W'(DATA_W - 1));
  assign stat.mul_done = mul_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (cmd.wr_push) begin
      sp <= sp + SP_W'(1);
    end else if (cmd.wr_result) begin
      sp <= sp - SP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q     <= op_t'(in_op);
      val_q    <= in_value[DATA_W-1:0];
      status_q <= ST_OK;
    end
    if (cmd.status_en) begin
      status_q <= cmd.status_code;
    end
    if (cmd.wr_push) begin
      tos <= val_q;
    end else if (cmd.wr_result) begin
      tos <= r_q;
    end
    if (cmd.load_a) begin
      a_q <= ram_rdata;
    end
    if (cmd.set_arith) begin
      r_q <= (op_q == OP_SUB) ? (a_q - tos) : (a_q + tos);
    end
    if (cmd.pow_init) begin
      r_q    <= DATA_W'(1);
      base_q <= a_q;
      ex_q   <= tos;
    end
    if (cmd.take_mul_r) begin
      r_q <= mul_p;
    end
    if (cmd.take_mul_base) begin
      base_q <= mul_p;
      ex_q   <= ex_q >> 1;
    end
    if (cmd.div_init) begin
      rem_q <= '0;
      quo_q <= mag_a;
      dvs_q <= mag_b;
      neg_q <= a_q[DATA_W-1] ^ tos[DATA_W-1];
      cnt   <= '0;
    end
    if (cmd.div_step) begin
      if (!div_diff[DATA_W]) begin
        rem_q <= div_diff[DATA_W-1:0];
      end else begin
        rem_q <= div_sh[DATA_W-1:0];
      end
      quo_q <= {quo_q[DATA_W-2:0], ~div_diff[DATA_W]};
      cnt   <= cnt + CNT_W'(1);
    end
    if (cmd.div_fin) begin
      r_q <= neg_q ? (DATA_W'(0) - quo_q) : quo_q;
    end
    if (cmd.load_out) begin
      out_top    <= (sp == '0) ? '0 : TOP_W'(signed'(tos));
      out_depth  <= DEPTH_W'(sp);
      out_status <= status_q;
    end
  end

endmodule

@@ hw/rtl/isa_ctrl.sv @@
// Controller state machine: sequences the datapath and runs both handshakes.
// Depends on isa_pkg.
module isa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output isa_pkg::cmd_t  cmd,
  input  isa_pkg::stat_t stat
);
  import isa_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        case (stat.op)
          OP_PUSH: state_next = S_DONE;
          OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POW:
            state_next = stat.lt2 ? S_DONE : S_READ;
          default: state_next = S_DONE;
        endcase
      end
      S_READ: state_next = S_EXEC;
      S_EXEC: begin
        case (stat.op)
          OP_ADD, OP_SUB: state_next = S_WRITE;
          OP_MUL:         state_next = S_MUL;
          OP_DIV:         state_next = stat.b_zero ? S_DONE : S_DIV;
          OP_POW:         state_next = stat.b_neg ? S_DONE : S_POW_CHK;
          default:        state_next = S_DONE;
        endcase
      end
      S_MUL:     if (stat.mul_done) state_next = S_WRITE;
      S_DIV:     if (stat.div_last) state_next = S_DIV_FIN;
      S_DIV_FIN: state_next = S_WRITE;
      S_POW_CHK: begin
        if (stat.ex_zero) begin
          state_next = S_WRITE;
        end else if (stat.ex_lsb) begin
          state_next = S_POW_MR;
        end else begin
          state_next = S_POW_SQ;
        end
      end
      S_POW_MR: if (stat.mul_done) state_next = S_POW_SQ;
      S_POW_SQ: if (stat.mul_done) state_next = S_POW_CHK;
      S_WRITE:  state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.mul_sel     = MS_AB;
    cmd.status_code = ST_OK;
    unique case (state)
      S_IDLE: cmd.load_in = in_valid;
      S_DECODE: begin
        case (stat.op)
          OP_PUSH: begin
            if (stat.full) begin
              cmd.status_en   = 1'b1;
              cmd.status_code = ST_OVER;
            end else begin
              cmd.wr_push = 1'b1;
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POW: begin
            if (stat.lt2) begin
              cmd.status_en   = 1'b1;
              cmd.status_code = ST_UNDER;
            end
          end
          default: cmd = cmd;
        endcase
      end
      S_READ: cmd.load_a = 1'b1;
      S_EXEC: begin
        case (stat.op)
          OP_ADD, OP_SUB: cmd.set_arith = 1'b1;
          OP_MUL:         cmd.mul_start = 1'b1;
          OP_DIV: begin
            if (stat.b_zero) begin
              cmd.status_en   = 1'b1;
              cmd.status_code = ST_DIVZ;
            end else begin
              cmd.div_init = 1'b1;
            end
          end
          OP_POW: begin
            if (stat.b_neg) begin
              cmd.status_en   = 1'b1;
              cmd.status_code = ST_NEGEXP;
            end else begin
              cmd.pow_init = 1'b1;
            end
          end
          default: cmd = cmd;
        endcase
      end
      S_MUL:     cmd.take_mul_r = stat.mul_done;
      S_DIV:     cmd.div_step = 1'b1;
      S_DIV_FIN: cmd.div_fin = 1'b1;
      S_POW_CHK: begin
        if (!stat.ex_zero) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = stat.ex_lsb ? MS_R_BASE : MS_BASE_SQ;
        end
      end
      S_POW_MR: begin
        if (stat.mul_done) begin
          cmd.take_mul_r = 1'b1;
          cmd.mul_start  = 1'b1;
          cmd.mul_sel    = MS_BASE_SQ;
        end
      end
      S_POW_SQ: cmd.take_mul_base = stat.mul_done;
      S_WRITE:  cmd.wr_result = 1'b1;
      S_DONE:   cmd.load_out = out_free;
      default:  cmd = cmd;
    endcase
  end

endmodule

@@ hw/rtl/integer_stack_alu_with_power_top.sv @@
// Channel   Dir  Signals                        Word
// input     in   s_tvalid s_tready s_tdata/user one push or operator
// output    out  m_tvalid m_tready m_tdata      one result per input word
//
// One word at a time. Multiply forms three half-width products on one multiplier;
// divide produces one quotient bit a cycle; power squares the base once per exponent
// bit (up to 63 bits) and also multiplies it into the result per set bit, both on
// the shared multiplier.
// Synchronous reset empties the stack; no clearing pass. A stalled output
// holds the result, one further input word may be taken meanwhile.
// Depends on isa_pkg, isa_ctrl, isa_dp and the macro header.
module integer_stack_alu_with_power_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // push_value[63:0]
  input  logic [2:0]  s_tuser,   // op[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata    // top_value[63:0], depth[70:64], status[73:71], zero
);
  import isa_pkg::*;
  `include "integer_stack_alu_with_power_top_macros.svh"

  cmd_t                cmd;
  stat_t               stat;
  logic [TOP_W-1:0]    out_top;
  logic [DEPTH_W-1:0]  out_depth;
  logic [2:0]          out_status;

  isa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  isa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_op     (s_tuser),
    .in_value  (s_tdata),
    .out_top   (out_top),
    .out_depth (out_depth),
    .out_status(out_status)
  );

  assign m_tdata = {6'd0, out_status, out_depth, out_top};

  `ISA_ASSERT_IMP(a_over_full, m_tvalid && (m_tdata[73:71] == ST_OVER), m_tdata[70:64] == DEPTH_W'(STACK_DEPTH), "overflow reported below full depth")
  `ISA_ASSERT_IMP(a_under_lt2, m_tvalid && (m_tdata[73:71] == ST_UNDER), m_tdata[70:64] < DEPTH_W'(2), "underflow reported with two or more entries")
  `ISA_ASSERT_IMP(a_empty_zero, m_tvalid && (m_tdata[70:64] == '0), m_tdata[63:0] == '0, "empty stack with nonzero top")
  `ISA_ASSERT_NXT(a_accept_busy, s_tvalid && s_tready, !s_tready, "second word taken during work")

endmodule
